FILE: rtl/icd_pkg.sv
`default_nettype none

package icd_pkg;

  localparam int unsigned HalfwordWidth = 16;
  localparam int unsigned LengthWidth   = 3;
  localparam int unsigned ClassWidth    = 6;

  // Instruction length in halfwords
  localparam logic [LengthWidth-1:0] LEN_16 = 3'd1;
  localparam logic [LengthWidth-1:0] LEN_32 = 3'd2;
  localparam logic [LengthWidth-1:0] LEN_48 = 3'd3;
  localparam logic [LengthWidth-1:0] LEN_80 = 3'd5;

  // Class codes
  localparam logic [ClassWidth-1:0] C16_ILLEGAL        = 6'd0;
  localparam logic [ClassWidth-1:0] C16_BKPT           = 6'd1;
  localparam logic [ClassWidth-1:0] C16_RTI            = 6'd11;
  localparam logic [ClassWidth-1:0] C16_SWI            = 6'd12;
  localparam logic [ClassWidth-1:0] C16_B              = 6'd13;
  localparam logic [ClassWidth-1:0] C16_SWITCH         = 6'd14;
  localparam logic [ClassWidth-1:0] C16_VERSION        = 6'd15;
  localparam logic [ClassWidth-1:0] C16_SWI_U          = 6'd16;
  localparam logic [ClassWidth-1:0] C16_LDM_STM        = 6'd17;
  localparam logic [ClassWidth-1:0] C16_LD_ST_SP       = 6'd18;
  localparam logic [ClassWidth-1:0] C16_LDW_STW        = 6'd19;
  localparam logic [ClassWidth-1:0] C16_ADD_SP         = 6'd20;
  localparam logic [ClassWidth-1:0] C16_B_COND         = 6'd21;
  localparam logic [ClassWidth-1:0] C16_LD_ST          = 6'd22;
  localparam logic [ClassWidth-1:0] C16_ALU_OP         = 6'd23;
  localparam logic [ClassWidth-1:0] C32_ADDCMPB        = 6'd24;
  localparam logic [ClassWidth-1:0] C32_B              = 6'd25;
  localparam logic [ClassWidth-1:0] C32_LD_ST_COND_IDX = 6'd26;
  localparam logic [ClassWidth-1:0] C32_LD_ST_DISP12   = 6'd27;
  localparam logic [ClassWidth-1:0] C32_LD_ST_PRE_POST = 6'd28;
  localparam logic [ClassWidth-1:0] C32_LD_ST_DISP16   = 6'd29;
  localparam logic [ClassWidth-1:0] C32_ALU_OP         = 6'd30;
  localparam logic [ClassWidth-1:0] C32_ALU_ADD        = 6'd31;
  localparam logic [ClassWidth-1:0] C32_ALU_ADD_PC     = 6'd32;
  localparam logic [ClassWidth-1:0] C32_ALU_COND       = 6'd33;
  localparam logic [ClassWidth-1:0] C32_ALU_FOP        = 6'd34;
  localparam logic [ClassWidth-1:0] C32_FTRUNC         = 6'd35;
  localparam logic [ClassWidth-1:0] C32_P_CONTROL      = 6'd39;
  localparam logic [ClassWidth-1:0] C48_DATA_VOP       = 6'd40;
  localparam logic [ClassWidth-1:0] C48_B              = 6'd41;
  localparam logic [ClassWidth-1:0] C48_ADD_PC_REL     = 6'd42;
  localparam logic [ClassWidth-1:0] C48_ADD_LD_ST      = 6'd43;
  localparam logic [ClassWidth-1:0] C48_ALU_OP         = 6'd44;
  localparam logic [ClassWidth-1:0] C48_ALU_ADD        = 6'd45;
  localparam logic [ClassWidth-1:0] C80_MEM_OP         = 6'd46;
  localparam logic [ClassWidth-1:0] C80_DATA_OP        = 6'd47;
  localparam logic [ClassWidth-1:0] CLASS_UNKNOWN      = 6'd48;

  // Highest single-halfword system opcode with a class of its own
  localparam logic [3:0] SysOpLast = 4'd10;

  typedef struct packed {
    logic [LengthWidth-1:0] length;
    logic [ClassWidth-1:0]  cls;
    logic                   recognized;
  } icd_result_t;

endpackage

`default_nettype wire

FILE: rtl/icd_classify.sv
`default_nettype none

module icd_classify
  import icd_pkg::*;
(
  input  wire logic [HalfwordWidth-1:0] h0,
  input  wire logic [HalfwordWidth-1:0] h1,
  output icd_result_t                   result
);

  logic [31:0]           w;
  logic [ClassWidth-1:0] cls16;
  logic [ClassWidth-1:0] cls32;
  logic [ClassWidth-1:0] cls48;
  logic [ClassWidth-1:0] cls80;

  assign w = {h0, h1};

  always_comb begin
    if ((h0 & 16'hfff0) == 16'h0000) begin
      // system opcodes map one-to-one starting at BKPT
      if (h0[3:0] <= SysOpLast) cls16 = C16_BKPT + ClassWidth'(h0[3:0]);
      else                      cls16 = C16_ILLEGAL;
    end
    else if ((h0 & 16'hffe0) == 16'h0020) cls16 = C16_SWI;
    else if ((h0 & 16'hffc0) == 16'h0040) cls16 = C16_B;
    else if ((h0 & 16'hffd0) == 16'h0080) cls16 = C16_SWITCH;
    else if ((h0 & 16'hffe0) == 16'h00e0) cls16 = C16_VERSION;
    else if ((h0 & 16'hffc0) == 16'h01c0) cls16 = C16_SWI_U;
    else if ((h0 & 16'hfe00) == 16'h0200) cls16 = C16_LDM_STM;
    else if ((h0 & 16'hfc00) == 16'h0400) cls16 = C16_LD_ST_SP;
    else if ((h0 & 16'hf800) == 16'h0800) cls16 = C16_LDW_STW;
    else if ((h0 & 16'hf800) == 16'h1000) cls16 = C16_ADD_SP;
    else if ((h0 & 16'hf800) == 16'h1800) cls16 = C16_B_COND;
    else if ((h0 & 16'he000) == 16'h2000) cls16 = C16_LD_ST;
    else if ((h0 & 16'hc000) == 16'h4000) cls16 = C16_ALU_OP;
    else                                  cls16 = CLASS_UNKNOWN;
  end

  always_comb begin
    if      ((w & 32'hf0000000) == 32'h80000000) cls32 = C32_ADDCMPB;
    else if ((w & 32'hf0000000) == 32'h90000000) cls32 = C32_B;
    else if ((w & 32'hff000060) == 32'ha0000000) cls32 = C32_LD_ST_COND_IDX;
    else if ((w & 32'hfe000000) == 32'ha2000000) cls32 = C32_LD_ST_DISP12;
    else if ((w & 32'hfe00007f) == 32'ha4000000) cls32 = C32_LD_ST_PRE_POST;
    else if ((w & 32'hfc000000) == 32'ha8000000) cls32 = C32_LD_ST_DISP16;
    else if ((w & 32'hfc000000) == 32'hb0000000) cls32 = C32_ALU_OP;
    else if ((w & 32'hfc000000) == 32'hb4000000) cls32 = C32_ALU_ADD;
    else if ((w & 32'hffe00000) == 32'hbfe00000) cls32 = C32_ALU_ADD_PC;
    else if ((w & 32'hf8000060) == 32'hc0000000 ||
             (w & 32'hf8000040) == 32'hc0000040) cls32 = C32_ALU_COND;
    else if ((w & 32'hfe000060) == 32'hc8000000 ||
             (w & 32'hfe000040) == 32'hc8000040) cls32 = C32_ALU_FOP;
    else if ((w & 32'hff800060) == 32'hca000000 ||
             (w & 32'hff800040) == 32'hca000040)
      // conversion kind sits in bits 22:21
      cls32 = C32_FTRUNC + ClassWidth'(w[22:21]);
    else if ((w & 32'hffc0ffe0) == 32'hcc000000) cls32 = C32_P_CONTROL;
    else                                         cls32 = CLASS_UNKNOWN;
  end

  always_comb begin
    if      ((h0 & 16'hfc00) == 16'hf400) cls48 = C48_DATA_VOP;
    else if ((h0 & 16'hfc00) == 16'he000) cls48 = C48_B;
    else if ((h0 & 16'hff00) == 16'he500) cls48 = C48_ADD_PC_REL;
    else if ((h0 & 16'hfe00) == 16'he600) cls48 = C48_ADD_LD_ST;
    else if ((h0 & 16'hfc00) == 16'he800) cls48 = C48_ALU_OP;
    else if ((h0 & 16'hfc00) == 16'hec00) cls48 = C48_ALU_ADD;
    else                                  cls48 = CLASS_UNKNOWN;
  end

  always_comb begin
    if      ((h0 & 16'hfc00) == 16'hf800) cls80 = C80_MEM_OP;
    else if ((h0 & 16'hfc00) == 16'hfc00) cls80 = C80_DATA_OP;
    else                                  cls80 = CLASS_UNKNOWN;
  end

  always_comb begin
    if (!h0[15]) begin
      result.length = LEN_16;
      result.cls    = cls16;
    end else if ((h0 & 16'hfc00) == 16'hf400) begin
      result.length = LEN_48;
      result.cls    = cls48;
    end else if ((h0 & 16'hf800) == 16'hf800) begin
      result.length = LEN_80;
      result.cls    = cls80;
    end else if ((h0 & 16'he000) == 16'he000) begin
      result.length = LEN_48;
      result.cls    = cls48;
    end else begin
      result.length = LEN_32;
      result.cls    = cls32;
    end
    result.recognized = (result.cls != CLASS_UNKNOWN);
  end

endmodule

`default_nettype wire

FILE: rtl/instruction_class_decoder.sv
`default_nettype none

// Channel  Handshake              Fields
// in       in_valid / in_ready    first_halfword, second_halfword, third_halfword
// out      out_valid / out_ready  length_halfwords, class_code, recognized
//
// One word per cycle sustained while the output is not stalled. Each
// word passes through the input register, then the result register;
// the decode in between is a single pass of mask/match logic.
// Synchronous reset empties both registers.
// A stalled output holds its word; the input register keeps accepting as
// long as the result register can take what it holds.

module instruction_class_decoder
  import icd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [HalfwordWidth-1:0] first_halfword,
  input  wire logic [HalfwordWidth-1:0] second_halfword,
  input  wire logic [HalfwordWidth-1:0] third_halfword,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [LengthWidth-1:0]        length_halfwords,
  output logic [ClassWidth-1:0]         class_code,
  output logic                          recognized
);

  logic                     s1_valid;
  logic [HalfwordWidth-1:0] s1_h0;
  logic [HalfwordWidth-1:0] s1_h1;
  logic [HalfwordWidth-1:0] s1_h2;
  logic                     out_free;
  icd_result_t              dec;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // third halfword is carried along but never looked at
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_h0 <= first_halfword;
      s1_h1 <= second_halfword;
      s1_h2 <= third_halfword;
    end
  end

  icd_classify u_classify (
    .h0     (s1_h0),
    .h1     (s1_h1 | (s1_h2 & 16'h0000)),
    .result (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      length_halfwords <= dec.length;
      class_code       <= dec.cls;
      recognized       <= dec.recognized;
    end
  end

  a_recog_matches_class: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (recognized == (class_code != CLASS_UNKNOWN)))
    else $error("recognized disagrees with class_code");

  a_length_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length_halfwords == LEN_16 || length_halfwords == LEN_32 ||
                   length_halfwords == LEN_48 || length_halfwords == LEN_80))
    else $error("illegal instruction length");

  a_len80_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && length_halfwords == LEN_80) |->
      (class_code == C80_MEM_OP || class_code == C80_DATA_OP ||
       class_code == CLASS_UNKNOWN))
    else $error("80-bit length with a non-80-bit class");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("input register word lost while output stalled");

endmodule

`default_nettype wire
